// ===== hdl/dpr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dpr_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_FOCAL_X  = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
    localparam logic [2:0] REG_CENTER_U = 3'd2;
    localparam logic [2:0] REG_CENTER_V = 3'd3;
    localparam logic [2:0] REG_BASELINE = 3'd4;
    localparam logic [2:0] REG_OFFSET   = 3'd5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // One classified pixel request between front and back
    typedef struct packed {
        logic [15:0] disparity;
        logic [12:0] row;
        logic [12:0] col;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } item_t;

    // Camera configuration
    typedef struct packed {
        logic [23:0] focal_x;
        logic [23:0] focal_y;
        logic [20:0] center_u;
        logic [20:0] center_v;
        logic [23:0] baseline;
        logic [19:0] offset;
    } cfg_t;

endpackage
`default_nettype wire

// ===== hdl/disparity_to_point_reprojection_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Stereo disparity to 3-D point reprojection. Each request is one pixel of a
// rectified disparity map with its color; a zero disparity yields no result,
// any other yields one point (X, negated Y, negated Z in signed Q23.8 mm,
// saturated) with the color passed through. Throughput is one pixel per clock
// while the output is not stalled; most of the pipeline stages lie in the
// bit-per-stage dividers for depth (42 stages) and for X/Y (34 stages).
// A short queue between the classifying front end and the arithmetic pipeline
// absorbs stalls; the pipeline advances whenever the output register is empty
// or being taken. The user must write the camera registers (cfg_wr_en/cfg_addr/
// cfg_wdata) only while the block is idle; the block does not enforce this.
module disparity_to_point_reprojection_top #(
    parameter int DISPARITY_BITS = 16
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                cfg_wr_en,
    input  wire [2:0]          cfg_addr,
    input  wire [23:0]         cfg_wdata,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire [15:0]         s_disparity,
    input  wire [12:0]         s_pixel_row,
    input  wire [12:0]         s_pixel_col,
    input  wire [7:0]          s_pixel_red,
    input  wire [7:0]          s_pixel_green,
    input  wire [7:0]          s_pixel_blue,
    output logic               m_valid,
    input  wire                m_ready,
    output logic signed [31:0] m_point_x,
    output logic signed [31:0] m_point_y,
    output logic signed [31:0] m_point_z,
    output logic [7:0]         m_point_red,
    output logic [7:0]         m_point_green,
    output logic [7:0]         m_point_blue
);
    import dpr_pkg::*;

    cfg_t  cfg_reg;
    item_t push_item, head;
    logic  push, full, pop, empty;

    // Camera registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.focal_x  <= 24'd1062931;
            cfg_reg.focal_y  <= 24'd1062931;
            cfg_reg.center_u <= 21'd329766;
            cfg_reg.center_v <= 21'd249234;
            cfg_reg.baseline <= 24'd45121;
            cfg_reg.offset   <= 20'd54550;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FOCAL_X:  cfg_reg.focal_x  <= cfg_wdata;
                REG_FOCAL_Y:  cfg_reg.focal_y  <= cfg_wdata;
                REG_CENTER_U: cfg_reg.center_u <= cfg_wdata[20:0];
                REG_CENTER_V: cfg_reg.center_v <= cfg_wdata[20:0];
                REG_BASELINE: cfg_reg.baseline <= cfg_wdata;
                REG_OFFSET:   cfg_reg.offset   <= cfg_wdata[19:0];
                default: ;
            endcase
        end
    end

    dpr_front #(.DISPARITY_BITS(DISPARITY_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_disparity(s_disparity), .s_pixel_row(s_pixel_row), .s_pixel_col(s_pixel_col),
        .s_pixel_red(s_pixel_red), .s_pixel_green(s_pixel_green),
        .s_pixel_blue(s_pixel_blue),
        .push(push), .push_item(push_item), .q_full(full)
    );

    dpr_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_item(push_item), .full(full),
        .pop(pop), .empty(empty), .head(head)
    );

    dpr_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .q_empty(empty), .q_head(head), .q_pop(pop),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_point_x(m_point_x), .m_point_y(m_point_y), .m_point_z(m_point_z),
        .m_point_red(m_point_red), .m_point_green(m_point_green),
        .m_point_blue(m_point_blue)
    );

endmodule
`default_nettype wire

// ===== hdl/dpr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dpr_front #(
    parameter int DISPARITY_BITS = 16
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire [15:0]          s_disparity,
    input  wire [12:0]          s_pixel_row,
    input  wire [12:0]          s_pixel_col,
    input  wire [7:0]           s_pixel_red,
    input  wire [7:0]           s_pixel_green,
    input  wire [7:0]           s_pixel_blue,
    output logic                push,
    output dpr_pkg::item_t      push_item,
    input  wire                 q_full
);
    import dpr_pkg::*;

    logic                      vld_reg;
    logic [DISPARITY_BITS-1:0] disp_reg;
    logic [12:0]               row_reg, col_reg;
    logic [7:0]                r_reg, g_reg, b_reg;
    logic [DISPARITY_BITS-1:0] disp_in;
    logic                      take;

    assign disp_in = s_disparity[DISPARITY_BITS-1:0];
    assign push    = vld_reg && !q_full;
    assign s_ready = !vld_reg || !q_full;
    assign take    = s_valid && s_ready;

    // Zero-disparity requests are accepted and dropped here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (take) begin
            vld_reg <= (disp_in != '0);
        end else if (push) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            disp_reg <= disp_in;
            row_reg  <= s_pixel_row;
            col_reg  <= s_pixel_col;
            r_reg    <= s_pixel_red;
            g_reg    <= s_pixel_green;
            b_reg    <= s_pixel_blue;
        end
    end

    always_comb begin
        push_item           = '0;
        push_item.disparity = 16'(disp_reg);
        push_item.row       = row_reg;
        push_item.col       = col_reg;
        push_item.red       = r_reg;
        push_item.green     = g_reg;
        push_item.blue      = b_reg;
    end

endmodule
`default_nettype wire

// ===== hdl/dpr_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dpr_fifo (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             push,
    input  dpr_pkg::item_t  push_item,
    output logic            full,
    input  wire             pop,
    output logic            empty,
    output dpr_pkg::item_t  head
);
    import dpr_pkg::*;

    item_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_reg, rd_reg;
    logic [QUEUE_AW:0]     cnt_reg;
    logic                  do_push, do_pop;

    assign full    = (cnt_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_reg];

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) wr_reg <= wr_reg + 1'b1;
            if (do_pop)  rd_reg <= rd_reg + 1'b1;
            if (do_push && !do_pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_reg] <= push_item;
    end

endmodule
`default_nettype wire

// ===== hdl/dpr_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
// ovf flags a quotient that does not fit in Q_W bits.
module dpr_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 25,
    parameter int Q_W   = 41,
    parameter int TAG_W = 8
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              en,
    input  wire              in_vld,
    input  wire [NUM_W-1:0]  in_num,
    input  wire [DEN_W-1:0]  in_den,
    input  wire [TAG_W-1:0]  in_tag,
    output logic             out_vld,
    output logic [Q_W-1:0]   out_q,
    output logic             out_ovf,
    output logic [TAG_W-1:0] out_tag
);
    localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W + 1 : DEN_W + Q_W + 1;

    logic             vld_reg [Q_W+1];
    logic [NUM_W-1:0] rem_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W+1];
    logic [TAG_W-1:0] tag_reg [Q_W+1];
    logic [Q_W-1:0]   q_reg   [Q_W+1];
    logic             ovf_reg [Q_W+1];

    // Entry stage: range check
    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg[0] <= 1'b0;
        else if (en)  vld_reg[0] <= in_vld;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= in_num;
            den_reg[0] <= in_den;
            tag_reg[0] <= in_tag;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (CW'(in_num) >= (CW'(in_den) << Q_W));
        end
    end

    for (genvar i = 1; i <= Q_W; i++) begin : g_stage
        localparam int B = Q_W - i;
        logic [CW-1:0] sh, r, diff;
        logic          ge;

        assign sh   = CW'(den_reg[i-1]) << B;
        assign r    = CW'(rem_reg[i-1]);
        assign ge   = (r >= sh);
        assign diff = r - sh;

        always_ff @(posedge aclk) begin
            if (!aresetn) vld_reg[i] <= 1'b0;
            else if (en)  vld_reg[i] <= vld_reg[i-1];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[i] <= den_reg[i-1];
                tag_reg[i] <= tag_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
                q_reg[i]   <= q_reg[i-1] | (ge ? (Q_W'(1) << B) : '0);
            end
        end

        if (i < Q_W) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) rem_reg[i] <= ge ? NUM_W'(diff) : rem_reg[i-1];
            end
        end
    end

    assign out_vld = vld_reg[Q_W];
    assign out_q   = q_reg[Q_W];
    assign out_ovf = ovf_reg[Q_W];
    assign out_tag = tag_reg[Q_W];

endmodule
`default_nettype wire

// ===== hdl/dpr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dpr_back (
    input  wire              aclk,
    input  wire              aresetn,
    input  dpr_pkg::cfg_t    cfg,
    input  wire              q_empty,
    input  dpr_pkg::item_t   q_head,
    output logic             q_pop,
    output logic             m_valid,
    input  wire              m_ready,
    output logic signed [31:0] m_point_x,
    output logic signed [31:0] m_point_y,
    output logic signed [31:0] m_point_z,
    output logic [7:0]       m_point_red,
    output logic [7:0]       m_point_green,
    output logic [7:0]       m_point_blue
);
    import dpr_pkg::*;

    localparam int ZTAG_W = 21 + 1 + 21 + 1 + 24;
    localparam int XTAG_W = 32 + 1 + 24;

    // Apply sign and clamp to signed 32 bits
    function automatic logic [31:0] sat_q(input logic neg, input logic big,
                                          input logic [32:0] mag);
        logic over;
        over = big || mag[32] || mag[31];
        if (neg) sat_q = over ? 32'h8000_0000 : (32'd0 - mag[31:0]);
        else     sat_q = over ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    logic        en;
    logic [23:0] fx, fy;
    logic        m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign q_pop   = en && !q_empty;
    assign fx      = (cfg.focal_x == '0) ? 24'd1 : cfg.focal_x;
    assign fy      = (cfg.focal_y == '0) ? 24'd1 : cfg.focal_y;

    // Stage A: depth numerator product, denominator, pixel offsets
    logic [20:0] col_q, row_q;
    logic        xneg_c, yneg_c;
    assign col_q  = {q_head.col, 8'd0};
    assign row_q  = {q_head.row, 8'd0};
    assign xneg_c = col_q < cfg.center_u;
    assign yneg_c = row_q < cfg.center_v;

    logic              a_vld_reg;
    logic [47:0]       a_prod_reg;
    logic [24:0]       a_den_reg;
    logic [ZTAG_W-1:0] a_tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) a_vld_reg <= 1'b0;
        else if (en)  a_vld_reg <= !q_empty;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_prod_reg <= fx * cfg.baseline;
            a_den_reg  <= {1'b0, q_head.disparity, 8'd0} + 25'(cfg.offset);
            a_tag_reg  <= {xneg_c ? cfg.center_u - col_q : col_q - cfg.center_u, xneg_c,
                           yneg_c ? cfg.center_v - row_q : row_q - cfg.center_v, yneg_c,
                           q_head.red, q_head.green, q_head.blue};
        end
    end

    // Stage B: add half divisor for rounding
    logic              b_vld_reg;
    logic [48:0]       b_num_reg;
    logic [24:0]       b_den_reg;
    logic [ZTAG_W-1:0] b_tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) b_vld_reg <= 1'b0;
        else if (en)  b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_num_reg <= 49'(a_prod_reg) + 49'(a_den_reg >> 1);
            b_den_reg <= a_den_reg;
            b_tag_reg <= a_tag_reg;
        end
    end

    // Depth divider
    logic              z_vld, z_ovf;
    logic [40:0]       z_q;
    logic [ZTAG_W-1:0] z_tag;

    dpr_div #(.NUM_W(49), .DEN_W(25), .Q_W(41), .TAG_W(ZTAG_W)) u_div_z (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(b_vld_reg), .in_num(b_num_reg), .in_den(b_den_reg), .in_tag(b_tag_reg),
        .out_vld(z_vld), .out_q(z_q), .out_ovf(z_ovf), .out_tag(z_tag)
    );

    logic [20:0] z_dx, z_dy;
    logic        z_xneg, z_yneg;
    logic [23:0] z_rgb;
    assign {z_dx, z_xneg, z_dy, z_yneg, z_rgb} = z_tag;

    // Stage C: partial products of offset times depth, depth output
    logic        c_vld_reg;
    logic [41:0] c_xlo_reg, c_ylo_reg;
    logic [40:0] c_xhi_reg, c_yhi_reg;
    logic [31:0] c_z_reg;
    logic        c_xneg_reg, c_yneg_reg;
    logic [23:0] c_rgb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) c_vld_reg <= 1'b0;
        else if (en)  c_vld_reg <= z_vld;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_xlo_reg  <= z_dx * z_q[20:0];
            c_xhi_reg  <= z_dx * z_q[40:21];
            c_ylo_reg  <= z_dy * z_q[20:0];
            c_yhi_reg  <= z_dy * z_q[40:21];
            c_z_reg    <= sat_q(z_q != '0, z_ovf || (z_q[40:33] != '0), z_q[32:0]);
            c_xneg_reg <= z_xneg;
            c_yneg_reg <= z_yneg;
            c_rgb_reg  <= z_rgb;
        end
    end

    // Stage D: combine partial products and rounding term
    logic              d_vld_reg;
    logic [62:0]       d_numx_reg, d_numy_reg;
    logic [XTAG_W-1:0] d_xtag_reg;
    logic              d_yneg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) d_vld_reg <= 1'b0;
        else if (en)  d_vld_reg <= c_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_numx_reg <= 63'(c_xlo_reg) + (63'(c_xhi_reg) << 21) + 63'(fx >> 1);
            d_numy_reg <= 63'(c_ylo_reg) + (63'(c_yhi_reg) << 21) + 63'(fy >> 1);
            d_xtag_reg <= {c_z_reg, c_xneg_reg, c_rgb_reg};
            d_yneg_reg <= c_yneg_reg;
        end
    end

    // X and Y dividers run in lockstep
    logic              x_vld, x_ovf, y_vld, y_ovf;
    logic [32:0]       x_q, y_q;
    logic [XTAG_W-1:0] x_tag;
    logic              y_tag;

    dpr_div #(.NUM_W(63), .DEN_W(24), .Q_W(33), .TAG_W(XTAG_W)) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(d_vld_reg), .in_num(d_numx_reg), .in_den(fx), .in_tag(d_xtag_reg),
        .out_vld(x_vld), .out_q(x_q), .out_ovf(x_ovf), .out_tag(x_tag)
    );

    dpr_div #(.NUM_W(63), .DEN_W(24), .Q_W(33), .TAG_W(1)) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(d_vld_reg), .in_num(d_numy_reg), .in_den(fy), .in_tag(d_yneg_reg),
        .out_vld(y_vld), .out_q(y_q), .out_ovf(y_ovf), .out_tag(y_tag)
    );

    logic [31:0] x_z;
    logic        x_xneg;
    logic [23:0] x_rgb;
    logic        x_zero, y_zero;
    assign {x_z, x_xneg, x_rgb} = x_tag;
    assign x_zero = (x_q == '0) && !x_ovf;
    assign y_zero = (y_q == '0) && !y_ovf;

    // Output register
    logic [31:0] px_reg, py_reg, pz_reg;
    logic [23:0] rgb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (en)  m_valid_reg <= x_vld && y_vld;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg  <= sat_q(x_xneg && !x_zero, x_ovf, x_q);
            py_reg  <= sat_q(!y_tag && !y_zero, y_ovf, y_q);
            pz_reg  <= x_z;
            rgb_reg <= x_rgb;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_point_x     = px_reg;
    assign m_point_y     = py_reg;
    assign m_point_z     = pz_reg;
    assign m_point_red   = rgb_reg[23:16];
    assign m_point_green = rgb_reg[15:8];
    assign m_point_blue  = rgb_reg[7:0];

endmodule
`default_nettype wire

// ===== tb/disparity_to_point_reprojection_top_tb.sv =====
`timescale 1ns / 1ps
module disparity_to_point_reprojection_top_tb;
    import dpr_pkg::*;

    localparam int DISP_BITS   = 16;
    localparam int PIPE_CYCLES = 120;
    localparam int RAND_ITEMS  = 1330;
    localparam longint CYCLE_LIMIT = 600000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [23:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_disparity = '0;
    logic [12:0] s_pixel_row = '0;
    logic [12:0] s_pixel_col = '0;
    logic [7:0]  s_pixel_red = '0;
    logic [7:0]  s_pixel_green = '0;
    logic [7:0]  s_pixel_blue = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [31:0] m_point_x, m_point_y, m_point_z;
    logic [7:0]  m_point_red, m_point_green, m_point_blue;

    disparity_to_point_reprojection_top #(.DISPARITY_BITS(DISP_BITS)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_disparity(s_disparity), .s_pixel_row(s_pixel_row),
        .s_pixel_col(s_pixel_col), .s_pixel_red(s_pixel_red),
        .s_pixel_green(s_pixel_green), .s_pixel_blue(s_pixel_blue),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_point_x(m_point_x), .m_point_y(m_point_y), .m_point_z(m_point_z),
        .m_point_red(m_point_red), .m_point_green(m_point_green),
        .m_point_blue(m_point_blue)
    );

    always #6 aclk = ~aclk;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } point_t;

    typedef struct {
        item_t  px;
        bit     known;  // expected point typed in below
        point_t pt;
    } vector_t;

    // Camera model held by the bench
    cfg_t   cam;
    point_t pending_points[$];
    int     mismatches = 0;
    longint cycle_count = 0;
    bit     hold_off = 1'b0;
    bit     rand_active = 1'b0;
    bit     stim_done = 1'b0;

    function automatic logic [63:0] round_div(logic [63:0] num, logic [63:0] den);
        return (num + den / 2) / den;
    endfunction

    function automatic logic signed [31:0] clamp_q(bit neg, logic [63:0] mag);
        if (neg)
            return (mag >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(mag[31:0]);
        return (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
    endfunction

    // Reproject one pixel; returns 0 when the pixel has no match
    function automatic bit reproject(item_t px, output point_t pt);
        logic [63:0] disp, fx, fy, den, depth, cq, rq, dx, dy, xm, ym;
        bit xneg, yneg;
        disp = 64'(px.disparity) & ((64'd1 << DISP_BITS) - 1);
        fx = (cam.focal_x == 0) ? 64'd1 : 64'(cam.focal_x);
        fy = (cam.focal_y == 0) ? 64'd1 : 64'(cam.focal_y);
        pt = '{default: '0};
        if (disp == 0)
            return 1'b0;
        den = (disp << 8) + 64'(cam.offset);
        depth = round_div(fx * 64'(cam.baseline), den);
        cq = 64'(px.col) << 8;
        rq = 64'(px.row) << 8;
        xneg = cq < 64'(cam.center_u);
        dx = xneg ? 64'(cam.center_u) - cq : cq - 64'(cam.center_u);
        yneg = rq < 64'(cam.center_v);
        dy = yneg ? 64'(cam.center_v) - rq : rq - 64'(cam.center_v);
        xm = round_div(dx * depth, fx);
        ym = round_div(dy * depth, fy);
        pt.x = clamp_q(xneg && xm != 0, xm);
        pt.y = clamp_q(!yneg && ym != 0, ym);
        pt.z = clamp_q(depth != 0, depth);
        pt.red = px.red;
        pt.green = px.green;
        pt.blue = px.blue;
        return 1'b1;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_FOCAL_X:  cam.focal_x  = val;
            REG_FOCAL_Y:  cam.focal_y  = val;
            REG_CENTER_U: cam.center_u = val[20:0];
            REG_CENTER_V: cam.center_v = val[20:0];
            REG_BASELINE: cam.baseline = val;
            REG_OFFSET:   cam.offset   = val[19:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_camera(logic [23:0] fx, logic [23:0] fy, logic [23:0] cu,
                               logic [23:0] cv, logic [23:0] bl, logic [23:0] off);
        write_reg(REG_FOCAL_X, fx);
        write_reg(REG_FOCAL_Y, fy);
        write_reg(REG_CENTER_U, cu);
        write_reg(REG_CENTER_V, cv);
        write_reg(REG_BASELINE, bl);
        write_reg(REG_OFFSET, off);
    endtask

    // Drain all points, then let zero-disparity requests flush
    task automatic wait_drained();
        while (pending_points.size() != 0)
            @(posedge aclk);
        repeat (PIPE_CYCLES) @(posedge aclk);
    endtask

    // Offer one pixel; valid stays up across back-to-back requests
    task automatic send_pixel(item_t px, bit known, point_t typed);
        point_t pt;
        s_valid       <= 1'b1;
        s_disparity   <= px.disparity;
        s_pixel_row   <= px.row;
        s_pixel_col   <= px.col;
        s_pixel_red   <= px.red;
        s_pixel_green <= px.green;
        s_pixel_blue  <= px.blue;
        do @(posedge aclk); while (!s_ready);
        if (reproject(px, pt))
            pending_points.insert(pending_points.size(), known ? typed : pt);
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    function automatic item_t random_pixel();
        item_t px;
        px.disparity = ($urandom_range(0, 9) == 0) ? 16'd0 :
                       ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                       16'($urandom_range(1, 255));
        px.row   = ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 1200));
        px.col   = ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 1600));
        px.red   = 8'($urandom);
        px.green = 8'($urandom);
        px.blue  = 8'($urandom);
        return px;
    endfunction

    task automatic random_phase(int count);
        int burst;
        point_t none;
        none = '{default: '0};
        while (count > 0) begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && count > 0; i++, count--)
                send_pixel(random_pixel(), 1'b0, none);
            idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
        end
        idle_gap(1);
    endtask

    // Directed table: pixels sent at reset defaults, all checked against reproject
    vector_t directed[] = '{
        '{'{16'd0, 13'd100, 13'd100, 8'd1, 8'd2, 8'd3}, 1'b0, '{default: '0}},
        '{'{16'hFFFF, 13'h1FFF, 13'h1FFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '{default: '0}},
        '{'{16'd1, 13'd0, 13'd0, 8'h00, 8'h00, 8'h00}, 1'b0, '{default: '0}},
        '{'{16'd1, 13'h1FFF, 13'd0, 8'hA5, 8'h5A, 8'hC3}, 1'b0, '{default: '0}},
        '{'{16'd64, 13'd0, 13'h1FFF, 8'h12, 8'h34, 8'h56}, 1'b0, '{default: '0}},
        '{'{16'h8000, 13'd973, 13'd1288, 8'h80, 8'h7F, 8'h01}, 1'b0, '{default: '0}},
        '{'{16'd0, 13'h1FFF, 13'h1FFF, 8'hFF, 8'h00, 8'hFF}, 1'b0, '{default: '0}},
        '{'{16'h5555, 13'h0AAA, 13'h1555, 8'hAA, 8'h55, 8'hAA}, 1'b0, '{default: '0}},
        '{'{16'hAAAA, 13'h1555, 13'h0AAA, 8'h55, 8'hAA, 8'h55}, 1'b0, '{default: '0}}
    };

    // Receiver: own stall pattern plus a long hold-off window
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else if (hold_off)
            m_ready <= 1'b0;
        else
            m_ready <= (cycle_count % 200 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    // Compare accepted points with the oldest prediction
    always @(posedge aclk) begin
        point_t want;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point x=%0d y=%0d z=%0d", m_point_x, m_point_y,
                             m_point_z);
            end else begin
                want = pending_points.pop_front();
                if (m_point_x !== want.x || m_point_y !== want.y || m_point_z !== want.z ||
                    m_point_red !== want.red || m_point_green !== want.green ||
                    m_point_blue !== want.blue) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("point mismatch: exp %0d %0d %0d rgb %h%h%h, got %0d %0d %0d rgb %h%h%h",
                                 want.x, want.y, want.z, want.red, want.green, want.blue,
                                 m_point_x, m_point_y, m_point_z, m_point_red,
                                 m_point_green, m_point_blue);
                end
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering, counted here
    initial begin
        wait (rand_active && !stim_done);
        repeat (60) @(posedge aclk);
        hold_off = 1'b1;
        repeat (300) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Timeout
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("disparity_to_point_reprojection_top test failed");
        $finish;
    end

    initial begin
        point_t none;
        none = '{default: '0};
        cam = '{focal_x: 24'd1062931, focal_y: 24'd1062931, center_u: 21'd329766,
                center_v: 21'd249234, baseline: 24'd45121, offset: 20'd54550};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset defaults
        foreach (directed[i])
            send_pixel(directed[i].px, directed[i].known, directed[i].pt);
        idle_gap(1);
        wait_drained();

        // Minimal camera: z equals baseline*1/den rounding to zero, all zero
        load_camera(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        send_pixel('{16'd1, 13'd5, 13'd7, 8'h11, 8'h22, 8'h33}, 1'b1,
                   '{32'sd0, 32'sd0, 32'sd0, 8'h11, 8'h22, 8'h33});
        send_pixel('{16'd3, 13'h1FFF, 13'h1FFF, 8'hEE, 8'hDD, 8'hCC}, 1'b0, none);
        idle_gap(1);
        wait_drained();

        // Extreme camera: saturation on every axis
        load_camera(24'hFFFFFF, 24'd1, 24'h1FFFFF, 24'h1FFFFF, 24'hFFFFFF, 24'd0);
        send_pixel('{16'd1, 13'd0, 13'd0, 8'h01, 8'h02, 8'h04}, 1'b1,
                   '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 8'h01, 8'h02,
                     8'h04});
        send_pixel('{16'hFFFF, 13'h1FFF, 13'h1FFF, 8'h08, 8'h10, 8'h20}, 1'b0, none);
        send_pixel('{16'd1, 13'h1FFF, 13'h1FFF, 8'h40, 8'h80, 8'hFF}, 1'b0, none);
        idle_gap(1);
        wait_drained();
        load_camera(24'd1, 24'hFFFFFF, 24'd0, 24'd0, 24'd1, 24'hFFFFF);
        send_pixel('{16'd1, 13'h1FFF, 13'h1FFF, 8'h00, 8'hFF, 8'h00}, 1'b0, none);
        idle_gap(1);
        wait_drained();

        // Out of range index must be ignored
        write_reg(3'd6, 24'hFFFFFF);
        write_reg(3'd7, 24'h000000);

        // Random phases over several camera settings
        load_camera(24'd1062931, 24'd1062931, 24'd329766, 24'd249234, 24'd45121,
                    24'd54550);
        rand_active = 1'b1;
        random_phase(RAND_ITEMS / 3);
        wait_drained();
        load_camera(24'($urandom_range(1, 24'hFFFFFF)), 24'($urandom_range(1, 24'hFFFFFF)),
                    24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
        random_phase(RAND_ITEMS / 3);
        wait_drained();
        load_camera(24'($urandom_range(20000, 400000)), 24'($urandom_range(20000, 400000)),
                    24'($urandom_range(0, 400000)), 24'($urandom_range(0, 300000)),
                    24'($urandom_range(0, 100000)), 24'($urandom_range(0, 100000)));
        random_phase(RAND_ITEMS - 2 * (RAND_ITEMS / 3));
        stim_done = 1'b1;
        wait_drained();

        if (mismatches == 0 && pending_points.size() == 0)
            $display("disparity_to_point_reprojection_top test passed");
        else
            $display("disparity_to_point_reprojection_top test failed");
        $finish;
    end
endmodule
